@@ src/mepq_pkg.sv @@
// shared constants, payload types and state codes for the min-extract priority queue
package mepq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int OCC_W    = 5;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIX,
		S_DONE
	} state_e_t;

	typedef struct packed {
		cmd_e_t                    command;
		logic signed [DATA_W-1:0]  value;
	} req_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  popped_value;
		status_e_t                 status;
		logic [OCC_W-1:0]          occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_idx;
	} scan_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] best_value;
		logic [ADDR_W-1:0]        best_idx;
		logic signed [DATA_W-1:0] last_value;
		logic                     busy;
	} scan_res_t;

endpackage

@@ src/mepq_ram.sv @@
// generic single-write, single-read RAM with registered read data
module mepq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/mepq_scan.sv @@
// minimum search over the entry words streaming out of the ram
module mepq_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mepq_pkg::scan_req_t              req,
	input  logic signed [mepq_pkg::DATA_W-1:0] rdata,
	output mepq_pkg::scan_res_t              res
);
	import mepq_pkg::*;

	logic                     en_s1;
	logic [ADDR_W-1:0]        idx_s1;
	logic signed [DATA_W-1:0] best_val_q;
	logic [ADDR_W-1:0]        best_idx_q;
	logic signed [DATA_W-1:0] last_val_q;
	logic                     take;

	// read data lines up with the index registered alongside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= req.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= req.rd_idx;
	end

	// first word seeds the search, strict less keeps the earlier slot
	assign take = en_s1 && ((idx_s1 == '0) || (rdata < best_val_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_val_q <= rdata;
			best_idx_q <= idx_s1;
		end
		if (en_s1) begin
			last_val_q <= rdata;
		end
	end

	assign res.best_value = best_val_q;
	assign res.best_idx   = best_idx_q;
	assign res.last_value = last_val_q;
	assign res.busy       = en_s1;

endmodule

@@ src/min_extract_priority_queue.sv @@
// Bounded min-extract priority queue of signed 32-bit values.
// Request channel (req_valid/req_ready, req): command push or pop, value for push.
// Response channel (rsp_valid/rsp_ready, rsp): one beat per request with the
// removed minimum, a status code and the entry count after the request.
// Entries live unordered in one ram; a pop scans the live entries one per cycle
// through the single read port, then moves the last entry into the freed slot.
// Equal minimums carry the same value, so which copy leaves is not visible.
// Push, pop on empty queue, push on full queue: the result is registered at accept
// and copied into the response register in the done state, then the block returns
// to idle and takes the next request. Pop of a queue holding n entries: the scan
// state reads one entry word per cycle over the read port, then the drain, fix
// (write-back) and done states follow; the response register is loaded in the done
// state before the block returns to idle for the next request.
// A new request is taken while the previous response still sits in the output
// register; the block then waits in its done state until the receiver takes it.
// Reset empties the queue at once (entry count to zero, ram contents are left).
// Pushing to a full queue drops the value with status full; popping an empty
// queue returns 0 with status empty.
module min_extract_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mepq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mepq_pkg::rsp_item_t rsp
);
	import mepq_pkg::*;

	state_e_t           state_q;
	state_e_t           state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  rd_idx_q;
	rsp_item_t          res_q;
	rsp_item_t          out_q;
	logic               out_valid_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic               scan_last;
	logic               load_out;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [DATA_W-1:0]  ram_rdata;
	scan_req_t          scan_req;
	scan_res_t          scan_res;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign scan_last = (CNT_W'(rd_idx_q) == (cnt_q - CNT_W'(1)));

	mepq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (scan_req.rd_en),
		.raddr(scan_req.rd_idx),
		.rdata(ram_rdata)
	);

	mepq_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (scan_req),
		.rdata (ram_rdata),
		.res   (scan_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == CMD_POP && !empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_FIX;
			S_FIX:   state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_ready       = 1'b0;
		ram_we          = 1'b0;
		ram_waddr       = ADDR_W'(cnt_q);
		ram_wdata       = req.value;
		scan_req.rd_en  = 1'b0;
		scan_req.rd_idx = rd_idx_q;
		load_out        = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				ram_we    = accept && (req.command == CMD_PUSH) && !full;
			end
			S_SCAN: scan_req.rd_en = 1'b1;
			S_FIX: begin
				// last entry fills the hole left by the minimum
				ram_we    = 1'b1;
				ram_waddr = scan_res.best_idx;
				ram_wdata = scan_res.last_value;
			end
			S_DONE:  load_out = !out_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				rd_idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
			if (ram_we && state_q == S_IDLE) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == S_FIX) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.popped_value <= '0;
			if (req.command == CMD_PUSH) begin
				res_q.status    <= full ? ST_FULL : ST_OK;
				res_q.occupancy <= full ? OCC_W'(cnt_q) : OCC_W'(cnt_q + CNT_W'(1));
			end else begin
				res_q.status    <= ST_EMPTY;
				res_q.occupancy <= OCC_W'(cnt_q);
			end
		end else if (state_q == S_FIX) begin
			res_q.popped_value <= scan_res.best_value;
			res_q.status       <= ST_OK;
			res_q.occupancy    <= OCC_W'(cnt_q - CNT_W'(1));
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
		(cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_fix_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIX |-> !empty && !scan_res.busy)
		else $error("write-back with empty queue or scan still running");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && scan_req.rd_en))
		else $error("ram write during scan");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q == S_IDLE |-> !full)
		else $error("push written into a full queue");
`endif

endmodule
